// ===== src/ete_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ete_pkg
// Shared widths, angle constants, arctangent table and fixed-point helpers
// for the equatorial to horizontal converter.
// ----------------------------------------------------------------------------
package ete_pkg;

    // field format
    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 24;
    localparam int RA_W          = 25;
    localparam int DEC_W         = 24;
    localparam int LMST_W        = 25;
    localparam int LAT_W         = 24;
    localparam int ALT_W         = 24;
    localparam int AZ_W          = 25;

    // internal formats: angles in degrees with 24 fraction bits, trig in Q30
    localparam int ANG_FRAC   = 24;
    localparam int ANG_SH     = ANG_FRAC - FRAC_BITS;
    localparam int ANG_W      = 34;
    localparam int TRIG_SHIFT = 30;
    localparam int TRIG_W     = 32;
    localparam int ROT_W      = 34;
    localparam int VEC_W      = 36;
    localparam int RAD_W      = 61;
    localparam int ROOT_W     = 31;
    localparam int N_ROT      = 3;
    localparam int N_VEC      = 2;

    typedef logic signed [ANG_W-1:0]  t_ang;
    typedef logic signed [ANG_W:0]    t_ang_wide;
    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [ROT_W-1:0]  t_rot;
    typedef logic signed [VEC_W-1:0]  t_vec;

    // sideband that rides along the square root pipeline
    typedef struct packed {
        t_trig                  s;
        t_trig                  ay;
        logic signed [TRIG_W:0] ax;
    } t_side;

    localparam t_ang  DEG90       = t_ang'(longint'(90) <<< ANG_FRAC);
    localparam t_ang  DEG180      = t_ang'(longint'(180) <<< ANG_FRAC);
    localparam t_ang  DEG360      = t_ang'(longint'(360) <<< ANG_FRAC);
    localparam t_ang  ROUND_HALF  = t_ang'((longint'(1) <<< ANG_SH) >>> 1);
    localparam t_ang  ALT_LIM     = t_ang'(longint'(90) <<< FRAC_BITS);
    localparam t_ang  AZ_FULL     = t_ang'(longint'(360) <<< FRAC_BITS);
    localparam t_trig TRIG_ONE    = t_trig'(longint'(1) <<< TRIG_SHIFT);
    localparam t_rot  CORDIC_GAIN = t_rot'(652032874);

    // atan(2^-i) in degrees with 24 fraction bits
    localparam t_ang ATAN_TAB [32] = '{
        34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
        34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
        34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
        34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
        34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
        34'sd917,       34'sd458,       34'sd229,       34'sd115,
        34'sd57,        34'sd29,        34'sd14,        34'sd7,
        34'sd4,         34'sd2,         34'sd1,         34'sd0
    };

    // clamp to [-1, 1] in Q30
    function automatic t_trig clamp_trig(input t_vec v);
        t_trig r;
        if (v > t_vec'(TRIG_ONE)) begin
            r = TRIG_ONE;
        end else if (v < -t_vec'(TRIG_ONE)) begin
            r = -TRIG_ONE;
        end else begin
            r = t_trig'(v);
        end
        return r;
    endfunction

    // Q30 product with floor
    function automatic t_trig qmul(input t_trig a, input t_trig b);
        logic signed [2*TRIG_W-1:0] p;
        p = a * b;
        return t_trig'(p >>> TRIG_SHIFT);
    endfunction

endpackage

// ===== src/ete_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ete_in_if / ete_out_if
// Valid/ready channels for the coordinate item and the result item.
// ----------------------------------------------------------------------------
interface ete_in_if import ete_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [RA_W-1:0]         right_ascension;
    logic signed [DEC_W-1:0] declination;
    logic [LMST_W-1:0]       sidereal_time;

    modport source (output valid, output right_ascension, output declination,
                    output sidereal_time, input ready);
    modport sink (input valid, input right_ascension, input declination,
                  input sidereal_time, output ready);
endinterface

interface ete_out_if import ete_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ALT_W-1:0] altitude;
    logic [AZ_W-1:0]         azimuth;

    modport source (output valid, output altitude, output azimuth, input ready);
    modport sink (input valid, input altitude, input azimuth, output ready);
endinterface

// ===== src/equatorial_to_horizontal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equatorial_to_horizontal
// Converts right ascension / declination to altitude / azimuth for an
// observer at the configured latitude, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  i_item   in   valid/ready  right_ascension, declination, sidereal_time
//  o_item   out  valid/ready  altitude, azimuth
//  cfg      in   i_cfg_we     i_cfg_wdata (latitude)
//
// One item per cycle unless the output stalls; in order: the sine/cosine CORDIC,
// the products, the square root, the atan2 CORDIC, the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall holds every stage and i_item.ready follows it.
// Synchronous active-low reset clears the valid bits and the latitude.
// ----------------------------------------------------------------------------
module equatorial_to_horizontal import ete_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LAT_W-1:0] i_cfg_wdata,
    ete_in_if.sink           i_item,
    ete_out_if.source        o_item
);

    logic                    w_en;
    logic signed [LAT_W-1:0] r_latitude;
    logic signed [RA_W:0]    w_diff;
    t_ang                    w_ha_raw;
    t_ang                    w_ha;
    t_ang                    w_rot_ang [N_ROT];
    logic                    w_sc_vld;
    t_trig                   w_sin [N_ROT];
    t_trig                   w_cos [N_ROT];

    logic                    r_m1_vld, r_m2_vld, r_m3_vld, r_m4_vld;
    t_trig                   r_p1, r_p2, r_p3, r_p4, r_p5, r_ch, r_cd;
    t_trig                   r_q1, r_q3, r_q5, r_p6, r_p7;
    t_trig                   r_s, r_ay;
    logic signed [TRIG_W:0]  r_ax;
    logic signed [2*TRIG_W-1:0] w_sq;
    logic [RAD_W-1:0]        r_rad;
    t_side                   r_side;

    logic                    w_sq_vld;
    logic [ROOT_W-1:0]       w_root;
    t_side                   w_side;
    t_vec                    w_vy [N_VEC];
    t_vec                    w_vx [N_VEC];
    logic                    w_at_vld;
    t_ang                    w_ang [N_VEC];

    t_ang                    w_alt_r;
    t_ang_wide               w_az0, w_az1, w_az2, w_az_r;
    logic                    r_out_vld;
    logic signed [ALT_W-1:0] r_alt;
    logic [AZ_W-1:0]         r_az;

    // pipeline advance
    assign w_en         = !r_out_vld || o_item.ready;
    assign i_item.ready = w_en;

    // latitude register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latitude <= '0;
        end else if (i_cfg_we) begin
            r_latitude <= $signed(i_cfg_wdata);
        end
    end

    // hour angle wrapped into (-180, 180]
    always_comb begin
        w_diff   = $signed({1'b0, i_item.sidereal_time})
                 - $signed({1'b0, i_item.right_ascension});
        w_ha_raw = t_ang'(w_diff) <<< ANG_SH;
        if (w_ha_raw > DEG180) begin
            w_ha = w_ha_raw - DEG360;
        end else if (w_ha_raw <= -DEG180) begin
            w_ha = w_ha_raw + DEG360;
        end else begin
            w_ha = w_ha_raw;
        end
        w_rot_ang[0] = t_ang'(r_latitude) <<< ANG_SH;
        w_rot_ang[1] = t_ang'(i_item.declination) <<< ANG_SH;
        w_rot_ang[2] = w_ha;
    end

    // sines and cosines of latitude, declination and hour angle
    ete_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_item.valid),
        .i_ang   (w_rot_ang),
        .o_valid (w_sc_vld),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // product valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_m3_vld <= 1'b0;
            r_m4_vld <= 1'b0;
        end else if (w_en) begin
            r_m1_vld <= w_sc_vld;
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= r_m2_vld;
            r_m4_vld <= r_m3_vld;
        end
    end

    assign w_sq = r_s * r_s;

    // first products, second products, sums, then the radicand
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1 <= qmul(w_sin[0], w_sin[1]);
            r_p2 <= qmul(w_cos[0], w_cos[1]);
            r_p3 <= qmul(w_sin[2], w_cos[1]);
            r_p4 <= qmul(w_cos[2], w_sin[0]);
            r_p5 <= qmul(w_sin[1], w_cos[0]);
            r_ch <= w_cos[2];
            r_cd <= w_cos[1];

            r_p6 <= qmul(r_p2, r_ch);
            r_p7 <= qmul(r_p4, r_cd);
            r_q1 <= r_p1;
            r_q3 <= r_p3;
            r_q5 <= r_p5;

            r_s  <= clamp_trig(t_vec'(r_q1) + t_vec'(r_p6));
            r_ay <= r_q3;
            r_ax <= (TRIG_W+1)'(r_p7) - (TRIG_W+1)'(r_q5);

            r_rad     <= RAD_W'((64'sd1 <<< (2 * TRIG_SHIFT)) - w_sq);
            r_side.s  <= r_s;
            r_side.ay <= r_ay;
            r_side.ax <= r_ax;
        end
    end

    // cosine of altitude
    ete_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_m4_vld),
        .i_rad   (r_rad),
        .i_side  (r_side),
        .o_valid (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_side)
    );

    // altitude lane and azimuth lane
    always_comb begin
        w_vy[0] = t_vec'(w_side.s);
        w_vx[0] = t_vec'({1'b0, w_root});
        w_vy[1] = t_vec'(w_side.ay);
        w_vx[1] = t_vec'(w_side.ax);
    end

    ete_atan2 u_atan2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_vld),
        .i_y     (w_vy),
        .i_x     (w_vx),
        .o_valid (w_at_vld),
        .o_ang   (w_ang)
    );

    // rounding and azimuth wrap into [0, 360); the altitude clamp is in the output register
    always_comb begin
        w_alt_r = (w_ang[0] + ROUND_HALF) >>> ANG_SH;
        w_az0   = t_ang_wide'(w_ang[1]) - t_ang_wide'(DEG180);
        if (w_az0 <= -t_ang_wide'(DEG360)) begin
            w_az1 = w_az0 + t_ang_wide'(DEG360);
        end else begin
            w_az1 = w_az0;
        end
        if (w_az1 < 0) begin
            w_az2 = w_az1 + t_ang_wide'(DEG360);
        end else begin
            w_az2 = w_az1;
        end
        w_az_r = (w_az2 + t_ang_wide'(ROUND_HALF)) >>> ANG_SH;
        if (w_az_r >= t_ang_wide'(AZ_FULL)) begin
            w_az_r = w_az_r - t_ang_wide'(AZ_FULL);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_at_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_alt_r > ALT_LIM) begin
                r_alt <= ALT_W'(ALT_LIM);
            end else if (w_alt_r < -ALT_LIM) begin
                r_alt <= ALT_W'(-ALT_LIM);
            end else begin
                r_alt <= ALT_W'(w_alt_r);
            end
            r_az <= AZ_W'(w_az_r);
        end
    end

    assign o_item.valid    = r_out_vld;
    assign o_item.altitude = r_alt;
    assign o_item.azimuth  = r_az;

`ifndef ASSERT_OFF
    // a held result stalls the input side
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_item.ready) |-> !i_item.ready)
        else $error("input accepted while output stalled");

    // altitude stays within +-90 degrees
    a_alt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((t_ang'(r_alt) <= ALT_LIM) && (t_ang'(r_alt) >= -ALT_LIM)))
        else $error("altitude out of range");

    // azimuth stays below 360 degrees
    a_az_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (t_ang'({1'b0, r_az}) < AZ_FULL))
        else $error("azimuth out of range");

    // results are produced only from items in the pipeline
    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && !w_at_vld) |=> !r_out_vld)
        else $error("result without item");
`endif

endmodule

// ===== src/ete_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ete_sincos
// Pipelined rotation CORDIC, one stage per iteration, several angle lanes.
// ----------------------------------------------------------------------------
module ete_sincos import ete_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_ang  i_ang [N_ROT],
    output logic  o_valid,
    output t_trig o_sin [N_ROT],
    output t_trig o_cos [N_ROT]
);

    t_rot  r_x   [CORDIC_STAGES+1][N_ROT];
    t_rot  r_y   [CORDIC_STAGES+1][N_ROT];
    t_ang  r_z   [CORDIC_STAGES+1][N_ROT];
    logic  r_neg [CORDIC_STAGES+1][N_ROT];
    t_trig r_sin [N_ROT];
    t_trig r_cos [N_ROT];
    logic  r_vld [CORDIC_STAGES+2];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORDIC_STAGES + 2; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < CORDIC_STAGES + 2; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // fold, rotation stages, sign fix and clamp
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < N_ROT; l++) begin
                r_x[0][l] <= CORDIC_GAIN;
                r_y[0][l] <= '0;
                if (i_ang[l] > DEG90) begin
                    r_z[0][l]   <= i_ang[l] - DEG180;
                    r_neg[0][l] <= 1'b1;
                end else if (i_ang[l] < -DEG90) begin
                    r_z[0][l]   <= i_ang[l] + DEG180;
                    r_neg[0][l] <= 1'b1;
                end else begin
                    r_z[0][l]   <= i_ang[l];
                    r_neg[0][l] <= 1'b0;
                end
                for (int k = 0; k < CORDIC_STAGES; k++) begin
                    r_neg[k+1][l] <= r_neg[k][l];
                    if (r_z[k][l] >= 0) begin
                        r_x[k+1][l] <= r_x[k][l] - (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] + (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] - ATAN_TAB[k];
                    end else begin
                        r_x[k+1][l] <= r_x[k][l] + (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] - (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] + ATAN_TAB[k];
                    end
                end
                r_sin[l] <= clamp_trig(r_neg[CORDIC_STAGES][l] ?
                                       t_vec'(-r_y[CORDIC_STAGES][l]) :
                                       t_vec'(r_y[CORDIC_STAGES][l]));
                r_cos[l] <= clamp_trig(r_neg[CORDIC_STAGES][l] ?
                                       t_vec'(-r_x[CORDIC_STAGES][l]) :
                                       t_vec'(r_x[CORDIC_STAGES][l]));
            end
        end
    end

    assign o_valid = r_vld[CORDIC_STAGES+1];
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

// ===== src/ete_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ete_isqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module ete_isqrt import ete_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic [RAD_W-1:0]  r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_root [ROOT_W+1];
    t_side             r_side [ROOT_W+1];
    logic              r_vld  [ROOT_W+1];
    logic [RAD_W+1:0]  w_trial [ROOT_W];

    // increment of the square when the next bit is set
    always_comb begin
        for (int j = 0; j < ROOT_W; j++) begin
            w_trial[j] = ((RAD_W+2)'(r_root[j]) << (ROOT_W - j))
                       | ((RAD_W+2)'(1) << (2 * (ROOT_W - 1 - j)));
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ROOT_W + 1; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int j = 1; j < ROOT_W + 1; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    // restoring stages, remainder kept as radicand minus root squared
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_rad;
            r_root[0] <= '0;
            r_side[0] <= i_side;
            for (int j = 0; j < ROOT_W; j++) begin
                r_side[j+1] <= r_side[j];
                if ({2'b00, r_rem[j]} >= w_trial[j]) begin
                    r_rem[j+1]  <= RAD_W'({2'b00, r_rem[j]} - w_trial[j]);
                    r_root[j+1] <= r_root[j] | (ROOT_W'(1) << (ROOT_W - 1 - j));
                end else begin
                    r_rem[j+1]  <= r_rem[j];
                    r_root[j+1] <= r_root[j];
                end
            end
        end
    end

    assign o_valid = r_vld[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_side  = r_side[ROOT_W];

endmodule

// ===== src/ete_atan2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ete_atan2
// Pipelined vectoring CORDIC giving atan2 in degrees, several lanes.
// ----------------------------------------------------------------------------
module ete_atan2 import ete_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_vec i_y [N_VEC],
    input  t_vec i_x [N_VEC],
    output logic o_valid,
    output t_ang o_ang [N_VEC]
);

    t_vec r_x    [CORDIC_STAGES+1][N_VEC];
    t_vec r_y    [CORDIC_STAGES+1][N_VEC];
    t_ang r_z    [CORDIC_STAGES+1][N_VEC];
    logic r_zero [CORDIC_STAGES+1][N_VEC];
    t_ang r_ang  [N_VEC];
    logic r_vld  [CORDIC_STAGES+2];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORDIC_STAGES + 2; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < CORDIC_STAGES + 2; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // left half-plane flip, vectoring stages, zero vector gives zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < N_VEC; l++) begin
                r_zero[0][l] <= (i_x[l] == '0) && (i_y[l] == '0);
                if (i_x[l] < 0) begin
                    r_x[0][l] <= -i_x[l];
                    r_y[0][l] <= -i_y[l];
                    r_z[0][l] <= (i_y[l] >= 0) ? DEG180 : -DEG180;
                end else begin
                    r_x[0][l] <= i_x[l];
                    r_y[0][l] <= i_y[l];
                    r_z[0][l] <= '0;
                end
                for (int k = 0; k < CORDIC_STAGES; k++) begin
                    r_zero[k+1][l] <= r_zero[k][l];
                    if (r_y[k][l] >= 0) begin
                        r_x[k+1][l] <= r_x[k][l] + (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] - (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] + ATAN_TAB[k];
                    end else begin
                        r_x[k+1][l] <= r_x[k][l] - (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] + (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] - ATAN_TAB[k];
                    end
                end
                r_ang[l] <= r_zero[CORDIC_STAGES][l] ? '0 : r_z[CORDIC_STAGES][l];
            end
        end
    end

    assign o_valid = r_vld[CORDIC_STAGES+1];
    assign o_ang   = r_ang;

endmodule

// ===== tb/sv/ete_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ete_checker
// Watches the coordinate and result channels, predicts altitude and azimuth
// for every accepted coordinate item with a bit-exact CORDIC model and
// compares each result item in order against the predicted values.
// ----------------------------------------------------------------------------
module ete_checker import ete_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LAT_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [RA_W-1:0]  i_ra,
    input  logic [DEC_W-1:0] i_dec,
    input  logic [LMST_W-1:0] i_lmst,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [ALT_W-1:0] i_alt,
    input  logic [AZ_W-1:0]  i_az,
    output int               o_errors,
    output int               o_pending
);

    typedef struct {
        logic [ALT_W-1:0] alt;
        logic [AZ_W-1:0]  az;
    } t_horiz;

    localparam longint ONE30 = longint'(1) <<< 30;
    localparam longint D180 = longint'(180) <<< 24;
    localparam longint D360 = longint'(360) <<< 24;

    t_horiz            horiz_q[$];
    logic [LAT_W-1:0]  site_lat;
    int                err_cnt;

    assign o_errors  = err_cnt;
    assign o_pending = horiz_q.size();

    // floor shift for signed 64-bit values
    function automatic longint fshr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint sat1(input longint v);
        if (v > ONE30) return ONE30;
        if (v < -ONE30) return -ONE30;
        return v;
    endfunction

    function automatic longint wrap_half(input longint a);
        longint r;
        r = a % D360;
        if (r > D180) r -= D360;
        else if (r <= -D180) r += D360;
        return r;
    endfunction

    function automatic longint atan_deg(input int i);
        return longint'(ATAN_TAB[i & 31]);
    endfunction

    function automatic void rot_sincos(input longint a, output longint s,
                                       output longint c);
        longint x, y, z, t;
        bit     flip;
        x = 652032874;
        y = 0;
        flip = 0;
        z = wrap_half(a);
        if (z > D180 / 2) begin
            z -= D180;
            flip = 1;
        end else if (z < -D180 / 2) begin
            z += D180;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (z >= 0) begin
                t = x - fshr(y, i);
                y = y + fshr(x, i);
                z -= atan_deg(i);
            end else begin
                t = x + fshr(y, i);
                y = y - fshr(x, i);
                z += atan_deg(i);
            end
            x = t;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = sat1(y);
        c = sat1(x);
    endfunction

    function automatic longint vec_angle(input longint y0, input longint x0);
        longint x, y, z, t;
        x = x0;
        y = y0;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? D180 : -D180;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (y >= 0) begin
                t = x + fshr(y, i);
                y = y - fshr(x, i);
                z += atan_deg(i);
            end else begin
                t = x - fshr(y, i);
                y = y + fshr(x, i);
                z -= atan_deg(i);
            end
            x = t;
        end
        return z;
    endfunction

    function automatic longint int_root(input longint v0);
        longint unsigned v, r, b;
        v = v0;
        r = 0;
        b = longint'(1) <<< 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint q30(input longint a, input longint b);
        return fshr(a * b, 30);
    endfunction

    function automatic longint to_out(input longint a);
        return fshr(a + (longint'(1) <<< (ANG_SH - 1)), ANG_SH);
    endfunction

    function automatic t_horiz predict_horiz(input logic [RA_W-1:0] ra,
                                             input logic [DEC_W-1:0] dec_f,
                                             input logic [LMST_W-1:0] lmst);
        longint dec, lat, ha, sl, cl, sd, cd, sh, ch, s, c, alt, az, ax, ay;
        longint lim, full;
        t_horiz r;
        dec = longint'(signed'(dec_f)) <<< ANG_SH;
        lat = longint'(signed'(site_lat)) <<< ANG_SH;
        ha = wrap_half((longint'(lmst) - longint'(ra)) <<< ANG_SH);
        rot_sincos(lat, sl, cl);
        rot_sincos(dec, sd, cd);
        rot_sincos(ha, sh, ch);
        s = sat1(q30(sl, sd) + q30(q30(cl, cd), ch));
        c = int_root(ONE30 * ONE30 - s * s);
        alt = to_out(vec_angle(s, c));
        lim = longint'(90) <<< FRAC_BITS;
        if (alt > lim) alt = lim;
        if (alt < -lim) alt = -lim;
        ay = q30(sh, cd);
        ax = q30(q30(ch, sl), cd) - q30(sd, cl);
        az = (vec_angle(ay, ax) - D180) % D360;
        if (az < 0) az += D360;
        az = to_out(az);
        full = longint'(360) <<< FRAC_BITS;
        if (az >= full) az -= full;
        r.alt = alt[ALT_W-1:0];
        r.az  = az[AZ_W-1:0];
        return r;
    endfunction

    // latitude shadow, prediction on input accept, compare on output accept
    always @(posedge i_clk) begin
        t_horiz want;
        int     bad;
        bad = 0;
        if (!i_rst_n) begin
            site_lat <= '0;
            err_cnt  <= 0;
            horiz_q.delete();
        end else begin
            if (i_cfg_we) site_lat <= i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                horiz_q.push_back(predict_horiz(i_ra, i_dec, i_lmst));
            if (i_out_valid && i_out_ready) begin
                if (horiz_q.size() == 0) begin
                    $error("unexpected result item alt=%0d az=%0d",
                           $signed(i_alt), i_az);
                    bad++;
                end else begin
                    want = horiz_q.pop_front();
                    if (want.alt !== i_alt) begin
                        $error("altitude: expected %0d actual %0d",
                               $signed(want.alt), $signed(i_alt));
                        bad++;
                    end
                    if (want.az !== i_az) begin
                        $error("azimuth: expected %0d actual %0d", want.az, i_az);
                        bad++;
                    end
                end
            end
            err_cnt <= err_cnt + bad;
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives coordinate items with random gaps and result back-pressure through
// several observer latitudes, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    import ete_pkg::*;

    localparam int LAT_MAX = 5898240;
    localparam int DEG_MAX = 23592959;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [LAT_W-1:0] cfg_wdata;
    int               err_total;
    int               pending;
    bit               long_hold;
    bit               hold_done;

    ete_in_if  coord_ch ();
    ete_out_if horiz_ch ();

    equatorial_to_horizontal i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (coord_ch),
        .o_item      (horiz_ch)
    );

    ete_checker i_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (coord_ch.valid),
        .i_in_ready  (coord_ch.ready),
        .i_ra        (coord_ch.right_ascension),
        .i_dec       (coord_ch.declination),
        .i_lmst      (coord_ch.sidereal_time),
        .i_out_valid (horiz_ch.valid),
        .i_out_ready (horiz_ch.ready),
        .i_alt       (horiz_ch.altitude),
        .i_az        (horiz_ch.azimuth),
        .o_errors    (err_total),
        .o_pending   (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // watchdog
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side back-pressure, with one long hold on request
    initial begin
        int gap;
        horiz_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold && !hold_done) begin
                horiz_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_done = 1'b1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                horiz_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            horiz_ch.ready <= 1'b1;
            @(posedge i_clk iff horiz_ch.valid);
        end
    end

    task automatic send_coord(input logic [RA_W-1:0] ra,
                              input logic [DEC_W-1:0] dec,
                              input logic [LMST_W-1:0] lmst, input bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            coord_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        coord_ch.valid           <= 1'b1;
        coord_ch.right_ascension <= ra;
        coord_ch.declination     <= dec;
        coord_ch.sidereal_time   <= lmst;
        @(posedge i_clk iff coord_ch.ready);
    endtask

    // pipeline drained: nothing pending, then the block's latency
    task automatic drain_all();
        coord_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_latitude(input logic [LAT_W-1:0] lat);
        cfg_we    <= 1'b1;
        cfg_wdata <= lat;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [DEC_W-1:0] rand_dec();
        return DEC_W'($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
    endfunction

    // stimulus
    initial begin
        logic [LAT_W-1:0] lats [6];
        int               odd;
        lats = '{LAT_W'(LAT_MAX), LAT_W'(-LAT_MAX), 24'd2621440,
                 LAT_W'(-24'sd1966080), 24'h7FFFFF, 24'h800000};
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        long_hold      = 1'b0;
        coord_ch.valid = 1'b0;
        coord_ch.right_ascension = '0;
        coord_ch.declination     = '0;
        coord_ch.sidereal_time   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, poles, zero vector, out-of-range patterns
        set_latitude(LAT_W'(LAT_MAX));
        send_coord('0, DEC_W'(LAT_MAX), '0, 1'b0);
        send_coord('0, DEC_W'(-LAT_MAX), '0, 1'b0);
        send_coord(RA_W'(DEG_MAX), '0, '0, 1'b0);
        send_coord('0, '0, LMST_W'(DEG_MAX), 1'b0);
        send_coord(25'h1FFFFFF, 24'h7FFFFF, 25'h1FFFFFF, 1'b0);
        send_coord(25'h1FFFFFF, 24'h800000, '0, 1'b0);
        send_coord('0, 24'h800000, 25'h1FFFFFF, 1'b0);
        drain_all();
        set_latitude('0);
        send_coord('0, '0, '0, 1'b0);
        send_coord(25'd11796480, '0, '0, 1'b0);
        send_coord('0, DEC_W'(LAT_MAX), 25'd5898240, 1'b0);
        send_coord(25'd5898240, DEC_W'(-LAT_MAX), '0, 1'b0);
        drain_all();
        set_latitude(LAT_W'(-LAT_MAX));
        send_coord('0, DEC_W'(-LAT_MAX), '0, 1'b0);
        send_coord(25'd11796480, DEC_W'(LAT_MAX), 25'd11796481, 1'b0);
        send_coord(25'd1, 24'd1, 25'd0, 1'b0);

        // stall the receiver while items keep coming
        long_hold = 1'b1;
        for (int i = 0; i < 150; i++)
            send_coord(RA_W'($urandom_range(0, DEG_MAX)), rand_dec(),
                       LMST_W'($urandom_range(0, DEG_MAX)), 1'b0);
        drain_all();

        // random phases across latitudes
        for (int p = 0; p < 6; p++) begin
            set_latitude(p == 5 ? LAT_W'($signed($urandom_range(0, 2 * LAT_MAX))
                                         - LAT_MAX) : lats[p]);
            for (int i = 0; i < 135; i++) begin
                odd = $urandom_range(0, 15);
                if (odd == 0)
                    send_coord(RA_W'($urandom), DEC_W'($urandom),
                               LMST_W'($urandom), 1'b1);
                else
                    send_coord(RA_W'($urandom_range(0, DEG_MAX)), rand_dec(),
                               LMST_W'($urandom_range(0, DEG_MAX)), (p % 2) == 0);
            end
            drain_all();
        end

        wait (hold_done);
        drain_all();
        if (err_total == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ete_pkg.sv
src/ete_if.sv
src/ete_sincos.sv
src/ete_isqrt.sv
src/ete_atan2.sv
src/equatorial_to_horizontal.sv
tb/sv/ete_checker.sv
tb/sv/testbench.sv
